// ----- rtl/core/qri_pkg.sv -----
`timescale 1ns / 1ps

package qri_pkg;

    // Field and datapath widths
    localparam int SAMPLE_W   = 32;               // Q16.16 sample
    localparam int BOUND_W    = 32;               // Q16.16 interval bound
    localparam int COUNT_W    = 17;               // interval count register
    localparam int RULE_W     = 2;
    localparam int STATUS_W   = 2;
    localparam int INTEGRAL_W = 64;               // Q47.16 result
    localparam int SUM_W      = 52;               // weighted sum, signed
    localparam int WIDTH_W    = 32;               // x_end - x_start, always positive
    localparam int DIVISOR_W  = 19;               // rule factor times count
    localparam int FRAC_W     = 16;               // Q16.16 scale folded into the divide
    localparam int QUOT_W     = SUM_W + WIDTH_W - FRAC_W;
    localparam int MUL_STEPS  = WIDTH_W;
    localparam int DIV_STEPS  = QUOT_W;
    localparam int STEP_W     = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // Largest count the 17-bit register can hold
    localparam int COUNT_MAX  = (1 << COUNT_W) - 1;

    // Rule codes
    localparam logic [RULE_W-1:0] RULE_RECT = 2'd0;
    localparam logic [RULE_W-1:0] RULE_TRAP = 2'd1;
    localparam logic [RULE_W-1:0] RULE_SIMP = 2'd2;

    // Status codes
    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_COUNT = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_ODD   = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_RULE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COUNT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_X_START = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_X_END   = 2'd3;

    // Saturation limits
    localparam logic [INTEGRAL_W-1:0] INTEGRAL_MAX = {1'b0, {(INTEGRAL_W-1){1'b1}}};
    localparam logic [INTEGRAL_W-1:0] INTEGRAL_MIN = {1'b1, {(INTEGRAL_W-1){1'b0}}};

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PREP,
        ST_CALC,
        ST_DONE
    } t_qri_state;

    typedef enum logic [1:0] {
        MD_IDLE,
        MD_MUL,
        MD_DIV
    } t_md_state;

endpackage

// ----- rtl/core/quadrature_rule_integrator.sv -----
`timescale 1ns / 1ps

// Channel  | Direction | Handshake                  | Payload
// ---------+-----------+----------------------------+------------------------------
// sample   | in        | i_in_valid / o_in_ready    | i_sample (Q16.16)
// result   | out       | o_out_valid / i_out_ready  | o_integral (Q47.16), o_status
// config   | in        | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// A sample that is not the last of the interval is taken with one 52-bit add.
// The last sample then passes through one setup state, 32 multiply steps and
// 68 divide steps on the shared adder of qri_muldiv, one hand-off and one output load.
// With an invalid configuration each request returns an error result in the next cycle.
// Reset is synchronous, active low; it restores register defaults and clears the sum.
// A pending register write holds off samples; a waiting result stalls those that need it.

module quadrature_rule_integrator import qri_pkg::*; #(
    parameter int MAX_INTERVALS = 65536
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // sample channel
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic signed [SAMPLE_W-1:0]   i_sample,
    // result channel
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic signed [INTEGRAL_W-1:0] o_integral,
    output logic [STATUS_W-1:0]          o_status,
    // configuration channel
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [CFG_DATA_W-1:0]        i_cfg_data
);

    // Effective count limit: the parameter, or what the register can hold
    localparam int EFF_MAX = (MAX_INTERVALS < COUNT_MAX) ? MAX_INTERVALS : COUNT_MAX;
    localparam logic [COUNT_W-1:0] EFF_LIM = COUNT_W'(EFF_MAX);

    // configuration registers
    logic [RULE_W-1:0]          r_rule;
    logic [COUNT_W-1:0]         r_count;
    logic signed [BOUND_W-1:0]  r_x_start;
    logic signed [BOUND_W-1:0]  r_x_end;

    // accumulation state
    t_qri_state r_state, n_state;
    logic signed [SUM_W-1:0]    r_sum;
    logic [COUNT_W-1:0]         r_taken;
    logic                       r_neg;

    // output register
    logic                       r_out_valid;
    logic [INTEGRAL_W-1:0]      r_integral;
    logic [STATUS_W-1:0]        r_status;

    logic [COUNT_W-1:0]         eff_n;
    logic [STATUS_W-1:0]        cfg_status;
    logic                       cfg_ok;
    logic                       is_last;
    logic                       end_point;
    logic [1:0]                 w_shift;
    logic signed [SUM_W-1:0]    term;
    logic                       in_accept;
    logic                       cfg_accept;
    logic                       out_free;
    logic                       md_start;
    logic                       load_err;
    logic                       load_res;
    logic [SUM_W-1:0]           md_mag;
    logic [WIDTH_W-1:0]         md_width;
    logic [DIVISOR_W-1:0]       md_divisor;
    logic [DIVISOR_W-1:0]       n_ext;
    logic                       md_done;
    logic [QUOT_W-1:0]          md_quot;
    logic [INTEGRAL_W-1:0]      sat_val;
    logic                       sat_over;

    assign eff_n = (r_count > EFF_LIM) ? EFF_LIM : r_count;

    // configuration check, in priority order
    always_comb begin
        if (r_x_start >= r_x_end) begin
            cfg_status = STATUS_RANGE;
        end else if (eff_n == '0) begin
            cfg_status = STATUS_COUNT;
        end else if (r_rule[1] && eff_n[0]) begin
            cfg_status = STATUS_ODD;    // Simpson, also for the unused rule code
        end else begin
            cfg_status = STATUS_OK;
        end
    end
    assign cfg_ok = (cfg_status == STATUS_OK);

    // sample weight as a shift: 1, 2 or 4
    assign end_point = (r_taken == '0) || (r_taken == eff_n);
    always_comb begin
        if (r_rule == RULE_RECT || end_point) begin
            w_shift = 2'd0;
        end else if (r_rule == RULE_TRAP) begin
            w_shift = 2'd1;
        end else begin
            w_shift = r_taken[0] ? 2'd2 : 2'd1;
        end
    end
    assign term = SUM_W'(i_sample) <<< w_shift;

    // rectangle rule skips the left end point, so it ends one sample sooner
    assign is_last = (r_rule == RULE_RECT) ? ((r_taken + COUNT_W'(1)) == eff_n)
                                           : (r_taken == eff_n);

    assign out_free   = !r_out_valid || i_out_ready;
    assign in_accept  = i_in_valid && o_in_ready;
    assign cfg_accept = i_cfg_valid && o_cfg_ready;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (in_accept && cfg_ok && is_last) n_state = ST_PREP;
            ST_PREP: n_state = ST_CALC;
            ST_CALC: if (md_done) n_state = ST_DONE;
            ST_DONE: if (out_free) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // control outputs; an error result needs the output register at once
    always_comb begin
        o_in_ready  = 1'b0;
        o_cfg_ready = 1'b0;
        md_start    = 1'b0;
        load_res    = 1'b0;
        case (r_state)
            ST_IDLE: begin
                // a pending register write goes first
                o_in_ready  = (cfg_ok || out_free) && !i_cfg_valid;
                o_cfg_ready = 1'b1;
            end
            ST_PREP: md_start = 1'b1;
            ST_CALC: begin
            end
            ST_DONE: load_res = out_free;
            default: begin
            end
        endcase
    end
    assign load_err = in_accept && !cfg_ok;

    // operands for the scale step: |sum| * width / (d * n * 2^16)
    assign md_mag   = r_sum[SUM_W-1] ? SUM_W'(-r_sum) : SUM_W'(r_sum);
    assign md_width = WIDTH_W'(r_x_end - r_x_start);
    assign n_ext    = DIVISOR_W'(eff_n);
    always_comb begin
        case (r_rule)
            RULE_RECT: md_divisor = n_ext;
            RULE_TRAP: md_divisor = n_ext << 1;
            default:   md_divisor = n_ext + (n_ext << 1);
        endcase
    end

    qri_muldiv u_muldiv (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (md_start),
        .i_mag     (md_mag),
        .i_width   (md_width),
        .i_divisor (md_divisor),
        .o_done    (md_done),
        .o_quot    (md_quot)
    );

    // signed result with saturation to 64 bits
    always_comb begin
        if (r_neg) begin
            sat_over = (|md_quot[QUOT_W-1:INTEGRAL_W])
                    || (md_quot[INTEGRAL_W-1] && (|md_quot[INTEGRAL_W-2:0]));
            sat_val  = sat_over ? INTEGRAL_MIN : INTEGRAL_W'(-md_quot[INTEGRAL_W-1:0]);
        end else begin
            sat_over = |md_quot[QUOT_W-1:INTEGRAL_W-1];
            sat_val  = sat_over ? INTEGRAL_MAX : md_quot[INTEGRAL_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_rule      <= RULE_RECT;
            r_count     <= COUNT_W'(1);
            r_x_start   <= '0;
            r_x_end     <= BOUND_W'(65536);
            r_sum       <= '0;
            r_taken     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            if (load_err || load_res) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            if (in_accept) begin
                if (!cfg_ok) begin
                    r_sum   <= '0;
                    r_taken <= '0;
                end else begin
                    r_sum   <= r_sum + term;
                    r_taken <= r_taken + COUNT_W'(1);
                end
            end

            // sum handed to the scale unit; start the next interval clean
            if (r_state == ST_PREP) begin
                r_sum   <= '0;
                r_taken <= '0;
            end

            if (cfg_accept) begin
                case (i_cfg_index)
                    REG_RULE:    r_rule    <= i_cfg_data[RULE_W-1:0];
                    REG_COUNT:   r_count   <= i_cfg_data[COUNT_W-1:0];
                    REG_X_START: r_x_start <= i_cfg_data[BOUND_W-1:0];
                    REG_X_END:   r_x_end   <= i_cfg_data[BOUND_W-1:0];
                    default: begin
                    end
                endcase
                r_sum   <= '0;
                r_taken <= '0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (r_state == ST_PREP) begin
            r_neg <= r_sum[SUM_W-1];
        end
        if (load_err) begin
            r_integral <= '0;
            r_status   <= cfg_status;
        end else if (load_res) begin
            r_integral <= sat_val;
            r_status   <= STATUS_OK;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_integral  = r_integral;
    assign o_status    = r_status;

endmodule

// ----- rtl/core/qri_muldiv.sv -----
`timescale 1ns / 1ps

// Shift-add multiply then restoring divide on one shared adder.
// quot = floor((mag * width) >> 16 / divisor)
module qri_muldiv import qri_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [SUM_W-1:0]     i_mag,
    input  logic [WIDTH_W-1:0]   i_width,
    input  logic [DIVISOR_W-1:0] i_divisor,
    output logic                 o_done,
    output logic [QUOT_W-1:0]    o_quot
);

    t_md_state r_state, n_state;
    logic [STEP_W-1:0]    r_step;
    logic                 r_done;
    logic [SUM_W-1:0]     r_acc;
    logic [WIDTH_W-1:0]   r_lo;
    logic [SUM_W-1:0]     r_mag;
    logic [DIVISOR_W-1:0] r_div;
    logic [DIVISOR_W-1:0] r_rem;
    logic [QUOT_W-1:0]    r_quo;

    logic [SUM_W:0]       add_a, add_b, add_sum;
    logic                 add_cin;
    logic [DIVISOR_W:0]   trial;
    logic                 mul_last, div_last;
    logic                 no_borrow;

    assign trial     = {r_rem, r_quo[QUOT_W-1]};
    assign mul_last  = (r_step == STEP_W'(MUL_STEPS - 1));
    assign div_last  = (r_step == STEP_W'(DIV_STEPS - 1));

    // shared adder: accumulate in multiply, trial subtract in divide
    always_comb begin
        case (r_state)
            MD_MUL: begin
                add_a   = {1'b0, r_acc};
                add_b   = r_lo[0] ? {1'b0, r_mag} : '0;
                add_cin = 1'b0;
            end
            MD_DIV: begin
                add_a   = (SUM_W+1)'(trial);
                add_b   = ~((SUM_W+1)'(r_div));
                add_cin = 1'b1;
            end
            default: begin
                add_a   = '0;
                add_b   = '0;
                add_cin = 1'b0;
            end
        endcase
    end

    assign add_sum   = add_a + add_b + (SUM_W+1)'(add_cin);
    assign no_borrow = ~add_sum[SUM_W];

    always_comb begin
        n_state = r_state;
        case (r_state)
            MD_IDLE: if (i_start)  n_state = MD_MUL;
            MD_MUL:  if (mul_last) n_state = MD_DIV;
            MD_DIV:  if (div_last) n_state = MD_IDLE;
            default: n_state = MD_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= MD_IDLE;
            r_step  <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == MD_DIV) && div_last;
            if (r_state == MD_IDLE || (r_state == MD_MUL && mul_last)) begin
                r_step <= '0;
            end else begin
                r_step <= r_step + STEP_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            MD_IDLE: begin
                if (i_start) begin
                    r_acc <= '0;
                    r_lo  <= i_width;
                    r_mag <= i_mag;
                    r_div <= i_divisor;
                end
            end
            MD_MUL: begin
                {r_acc, r_lo} <= {add_sum, r_lo[WIDTH_W-1:1]};
                if (mul_last) begin
                    // product >> 16 becomes the dividend
                    r_quo <= {add_sum, r_lo[WIDTH_W-1:FRAC_W+1]};
                    r_rem <= '0;
                end
            end
            MD_DIV: begin
                r_rem <= no_borrow ? add_sum[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
                r_quo <= {r_quo[QUOT_W-2:0], no_borrow};
            end
            default: begin
            end
        endcase
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

endmodule

// ----- dv/quadrature_rule_integrator_tb.sv -----
`timescale 1ns / 1ps

module quadrature_rule_integrator_tb;
    import qri_pkg::*;

    localparam int MAX_INTERVALS  = 65536;
    // Covers the calculation after the last sample of a set, with margin, before a register write.
    localparam int LATENCY_CYCLES = 128;
    localparam int RANDOM_ITEMS   = 1150;
    // Samples sent into the clamped-count Simpson set before it is dropped
    localparam int LONG_SET_PART  = 40;
    // Rule code 3 has no name in the package; the block treats it as Simpson.
    localparam logic [RULE_W-1:0] RULE_SPARE = 2'd3;

    // Sender idle behavior per request
    localparam int GAP_NONE  = 0;
    localparam int GAP_SHORT = 1;
    localparam int GAP_MIXED = 2;

    typedef struct packed {
        logic [INTEGRAL_W-1:0] integral;
        logic [STATUS_W-1:0]   status;
    } t_integral_result;

    typedef enum logic {ROW_CFG, ROW_SAMPLE} t_row_kind;

    // One line of the directed sequence: either a register write or a sample.
    // Rows with 'typed' set carry a hand-computed result; others go through the predictor.
    typedef struct packed {
        t_row_kind              kind;
        logic [CFG_IDX_W-1:0]   index;
        logic [CFG_DATA_W-1:0]  data;
        logic                   typed;
        t_integral_result       want;
    } t_stim_row;

    // Clock, reset and DUT inputs, all known from time zero
    logic                         i_clk       = 1'b0;
    logic                         i_rst_n     = 1'b0;
    logic                         i_in_valid  = 1'b0;
    logic signed [SAMPLE_W-1:0]   i_sample    = '0;
    logic                         i_out_ready = 1'b0;
    logic                         i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]         i_cfg_index = REG_RULE;
    logic [CFG_DATA_W-1:0]        i_cfg_data  = '0;
    logic                         o_in_ready;
    logic                         o_out_valid;
    logic signed [INTEGRAL_W-1:0] o_integral;
    logic [STATUS_W-1:0]          o_status;
    logic                         o_cfg_ready;

    // Predictor copy of the registers (reset values) and the running accumulation
    logic [RULE_W-1:0]          cfg_rule    = RULE_RECT;
    logic [COUNT_W-1:0]         cfg_count   = 17'd1;
    logic signed [BOUND_W-1:0]  cfg_x_start = 32'sh0000_0000;
    logic signed [BOUND_W-1:0]  cfg_x_end   = 32'sh0001_0000;
    longint                     weighted_acc  = 0;
    int unsigned                samples_in_set = 0;

    // Integrals predicted but not yet seen on the result port, oldest first
    t_integral_result awaited_results[$];
    t_integral_result head_result;

    int mismatch_count   = 0;
    int samples_sent     = 0;
    int random_samples   = 0;
    int long_set_samples = 0;
    int register_writes  = 0;
    int results_checked  = 0;
    int error_results    = 0;

    quadrature_rule_integrator #(
        .MAX_INTERVALS (MAX_INTERVALS)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_sample    (i_sample),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_integral  (o_integral),
        .o_status    (o_status),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Counts above the parameter clamp to it
    function automatic int unsigned effective_count();
        int unsigned n;
        n = 32'(cfg_count);
        if (n > MAX_INTERVALS) n = MAX_INTERVALS;
        return n;
    endfunction

    // Error precedence: bounds first, then zero count, then odd Simpson count
    function automatic logic [STATUS_W-1:0] config_status();
        int unsigned n;
        n = effective_count();
        if (cfg_x_start >= cfg_x_end) return STATUS_RANGE;
        if (n == 0) return STATUS_COUNT;
        if (cfg_rule >= RULE_SIMP && (n % 2) != 0) return STATUS_ODD;
        return STATUS_OK;
    endfunction

    // |sum| * width / (rule_den * n * 2^16), truncated toward zero, then saturated
    function automatic logic [INTEGRAL_W-1:0] scale_integral(input int unsigned n);
        logic [127:0] magnitude;
        logic [127:0] divisor;
        logic [127:0] quotient;
        longint       span;
        int unsigned  rule_den;
        logic         negative;
        span      = longint'($signed(cfg_x_end)) - longint'($signed(cfg_x_start));
        rule_den  = (cfg_rule == RULE_RECT) ? 1 : ((cfg_rule == RULE_TRAP) ? 2 : 3);
        negative  = weighted_acc < 0;
        magnitude = negative ? 128'(-weighted_acc) : 128'(weighted_acc);
        divisor   = (128'(rule_den) * 128'(n)) << FRAC_W;
        quotient  = (magnitude * 128'(span)) / divisor;
        if (negative) begin
            if (quotient > 128'(INTEGRAL_MIN)) return INTEGRAL_MIN;
            return -quotient[INTEGRAL_W-1:0];
        end
        if (quotient > 128'(INTEGRAL_MAX)) return INTEGRAL_MAX;
        return quotient[INTEGRAL_W-1:0];
    endfunction

    // Folds one sample into the running sum; returns 1 when a result is due
    function automatic bit integrate_sample(input logic [SAMPLE_W-1:0] value,
                                            output logic [INTEGRAL_W-1:0] integral,
                                            output logic [STATUS_W-1:0] status);
        int unsigned n;
        int unsigned set_size;
        int unsigned k;
        longint      weight;
        status   = config_status();
        integral = '0;
        if (status != STATUS_OK) begin
            weighted_acc   = 0;
            samples_in_set = 0;
            return 1'b1;
        end
        n        = effective_count();
        set_size = (cfg_rule == RULE_RECT) ? n : n + 1;
        k        = samples_in_set;
        if (cfg_rule == RULE_RECT || k == 0 || k == n) weight = 1;
        else if (cfg_rule == RULE_TRAP) weight = 2;
        else weight = (k % 2 != 0) ? 4 : 2;
        weighted_acc   += weight * longint'($signed(value));
        samples_in_set  = k + 1;
        if (samples_in_set < set_size) return 1'b0;
        integral       = scale_integral(n);
        weighted_acc   = 0;
        samples_in_set = 0;
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Mostly back-to-back, some short gaps, a few long ones
    function automatic int idle_gap(input int mode);
        int r;
        if (mode == GAP_NONE) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92 || mode == GAP_SHORT) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Full-scale random with extra weight on the rails and on small values
    function automatic logic [SAMPLE_W-1:0] pick_sample();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) begin
            case ($urandom_range(0, 3))
                0:       return 32'h7FFF_FFFF;
                1:       return 32'h8000_0000;
                2:       return 32'h0000_0000;
                default: return 32'hFFFF_FFFF;
            endcase
        end
        if (r < 3) return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
        return $urandom;
    endfunction

    // Valid stays up across back-to-back requests; it only drops ahead of a gap
    task automatic send_sample(input logic [SAMPLE_W-1:0] value, input int gap_mode,
                               input bit typed, input t_integral_result typed_result);
        int                    gap;
        bit                    produced;
        logic [INTEGRAL_W-1:0] integral;
        logic [STATUS_W-1:0]   status;
        t_integral_result      predicted;
        gap = idle_gap(gap_mode);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_sample   <= value;
        do @(posedge i_clk); while (!o_in_ready);
        produced = integrate_sample(value, integral, status);
        predicted.integral = integral;
        predicted.status   = status;
        if (typed) awaited_results.push_back(typed_result);
        else if (produced) awaited_results.push_back(predicted);
        samples_sent++;
    endtask

    // Sender holds off until every predicted integral has been taken
    task automatic pause_for_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (awaited_results.size() != 0);
    endtask

    // Block must be idle before a register write; a partial set leaves no result to wait for
    task automatic drain_and_settle();
        pause_for_results();
        repeat (LATENCY_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                  input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (index)
            REG_RULE:    cfg_rule    = data[RULE_W-1:0];
            REG_COUNT:   cfg_count   = data[COUNT_W-1:0];
            REG_X_START: cfg_x_start = data;
            REG_X_END:   cfg_x_end   = data;
            default:     ;
        endcase
        // any write restarts the accumulation
        weighted_acc   = 0;
        samples_in_set = 0;
        register_writes++;
    endtask

    task automatic end_register_writes();
        i_cfg_valid <= 1'b0;
    endtask

    function automatic t_stim_row cfg_row(input logic [CFG_IDX_W-1:0] index,
                                          input logic [CFG_DATA_W-1:0] data);
        t_stim_row row;
        row       = '0;
        row.kind  = ROW_CFG;
        row.index = index;
        row.data  = data;
        return row;
    endfunction

    function automatic t_stim_row sample_row(input logic [SAMPLE_W-1:0] value);
        t_stim_row row;
        row      = '0;
        row.kind = ROW_SAMPLE;
        row.data = value;
        return row;
    endfunction

    function automatic t_stim_row checked_row(input logic [SAMPLE_W-1:0] value,
                                              input logic [INTEGRAL_W-1:0] integral,
                                              input logic [STATUS_W-1:0] status);
        t_stim_row row;
        row               = sample_row(value);
        row.typed         = 1'b1;
        row.want.integral = integral;
        row.want.status   = status;
        return row;
    endfunction

    // ------------------------------------------------------------------
    // Result side: random backpressure and the scoreboard check
    // ------------------------------------------------------------------

    initial begin : result_backpressure
        int stall;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            i_out_ready <= 1'b1;
            repeat ($urandom_range(1, 40)) @(posedge i_clk);
            stall = idle_gap(GAP_MIXED);
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (awaited_results.size() == 0) begin
                $error("unexpected result: integral %0d, status %0d", o_integral, o_status);
                mismatch_count++;
            end else begin
                head_result = awaited_results.pop_front();
                if (o_integral !== head_result.integral) begin
                    $error("integral mismatch: expected %0d, actual %0d",
                           $signed(head_result.integral), o_integral);
                    mismatch_count++;
                end
                if (o_status !== head_result.status) begin
                    $error("status mismatch: expected %0d, actual %0d",
                           head_result.status, o_status);
                    mismatch_count++;
                end
                results_checked++;
                if (head_result.status != STATUS_OK) error_results++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------

    initial begin : stimulus
        t_stim_row        directed_rows[$];
        t_stim_row        row;
        t_integral_result no_result;
        bit               in_cfg_batch;
        bit               wrote;
        int               set_size;
        int               requests;
        int               gap_mode;
        logic [CFG_DATA_W-1:0] reg_data;
        logic [BOUND_W-1:0]    lo_bound;
        logic [BOUND_W-1:0]    hi_bound;
        logic [BOUND_W-1:0]    swap;

        no_result    = '0;
        in_cfg_batch = 1'b0;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset config is rectangle, n = 1, over [0, 1): each sample comes back as its own
        // value in Q47.16, so the rails are easy to read off.
        directed_rows.push_back(checked_row(32'h0001_0000, 64'd65536, STATUS_OK));
        directed_rows.push_back(checked_row(32'h7FFF_FFFF, 64'h0000_0000_7FFF_FFFF, STATUS_OK));
        directed_rows.push_back(checked_row(32'h8000_0000, 64'hFFFF_FFFF_8000_0000, STATUS_OK));
        directed_rows.push_back(checked_row(32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, STATUS_OK));
        // Empty interval
        directed_rows.push_back(cfg_row(REG_X_END, 32'h0000_0000));
        directed_rows.push_back(checked_row(32'h1234_5678, '0, STATUS_RANGE));
        // Zero count
        directed_rows.push_back(cfg_row(REG_X_END, 32'h0001_0000));
        directed_rows.push_back(cfg_row(REG_COUNT, 32'd0));
        directed_rows.push_back(checked_row(32'h0000_0000, '0, STATUS_COUNT));
        // Odd count under Simpson
        directed_rows.push_back(cfg_row(REG_RULE, 32'(RULE_SIMP)));
        directed_rows.push_back(cfg_row(REG_COUNT, 32'd3));
        directed_rows.push_back(checked_row(32'h7FFF_FFFF, '0, STATUS_ODD));
        // Reversed bounds outrank the odd-count and zero-count errors
        directed_rows.push_back(cfg_row(REG_X_START, 32'h0002_0000));
        directed_rows.push_back(checked_row(32'h0000_0000, '0, STATUS_RANGE));
        directed_rows.push_back(cfg_row(REG_COUNT, 32'd0));
        directed_rows.push_back(checked_row(32'hFFFF_FFFF, '0, STATUS_RANGE));
        // Widest interval, Simpson n = 2 at the positive rail
        directed_rows.push_back(cfg_row(REG_X_START, 32'h8000_0000));
        directed_rows.push_back(cfg_row(REG_X_END, 32'h7FFF_FFFF));
        directed_rows.push_back(cfg_row(REG_COUNT, 32'd2));
        repeat (3) directed_rows.push_back(sample_row(32'h7FFF_FFFF));
        // Spare rule code, expected to weight and scale like Simpson
        directed_rows.push_back(cfg_row(REG_RULE, 32'(RULE_SPARE)));
        directed_rows.push_back(sample_row(32'h8000_0000));
        directed_rows.push_back(sample_row(32'h7FFF_FFFF));
        directed_rows.push_back(sample_row(32'h8000_0000));
        // Trapezoid n = 4: a partial set is dropped by a register write, then a full set
        directed_rows.push_back(cfg_row(REG_RULE, 32'(RULE_TRAP)));
        directed_rows.push_back(cfg_row(REG_COUNT, 32'd4));
        directed_rows.push_back(sample_row(32'h0000_0001));
        directed_rows.push_back(sample_row(32'h0000_0002));
        directed_rows.push_back(cfg_row(REG_X_START, 32'hFFFF_0000));
        directed_rows.push_back(sample_row(32'h0001_0000));
        directed_rows.push_back(sample_row(32'hFFFE_0000));
        directed_rows.push_back(sample_row(32'h7FFF_FFFF));
        directed_rows.push_back(sample_row(32'h8000_0000));
        directed_rows.push_back(sample_row(32'h0000_0001));

        foreach (directed_rows[r]) begin
            row = directed_rows[r];
            if (row.kind == ROW_CFG) begin
                if (!in_cfg_batch) drain_and_settle();
                write_register(row.index, row.data);
                in_cfg_batch = 1'b1;
            end else begin
                if (in_cfg_batch) end_register_writes();
                in_cfg_batch = 1'b0;
                send_sample(row.data, GAP_MIXED, row.typed, row.want);
            end
        end

        // Simpson with a raw count of 65537: it clamps to 65536, which is even, so the
        // samples are summed with no error result. The set is cut short by a write.
        drain_and_settle();
        reg_data = $urandom;
        reg_data[COUNT_W-1:0] = 17'h1_0001;
        write_register(REG_RULE, 32'(RULE_SIMP));
        write_register(REG_COUNT, reg_data);
        write_register(REG_X_START, 32'hFFFF_8000);
        write_register(REG_X_END, 32'h0002_8000);
        end_register_writes();
        repeat (LONG_SET_PART) begin
            send_sample(pick_sample(), GAP_SHORT, 1'b0, no_result);
            long_set_samples++;
        end
        drain_and_settle();
        write_register(REG_COUNT, 32'd2);
        end_register_writes();

        // Random phases: new settings, then mostly complete sets with random samples,
        // sometimes a trailing partial set that the next write throws away.
        while (random_samples < RANDOM_ITEMS) begin
            drain_and_settle();
            wrote = 1'b0;
            if ($urandom_range(0, 1) == 1) begin
                reg_data = $urandom;
                reg_data[RULE_W-1:0] = RULE_W'($urandom_range(0, 3));
                write_register(REG_RULE, reg_data);
                wrote = 1'b1;
            end
            if ($urandom_range(0, 1) == 1) begin
                reg_data = $urandom;
                case ($urandom_range(0, 19))
                    0:       reg_data[COUNT_W-1:0] = '0;
                    1, 2:    reg_data[COUNT_W-1:0] = COUNT_W'($urandom_range(9, 48));
                    default: reg_data[COUNT_W-1:0] = COUNT_W'($urandom_range(1, 8));
                endcase
                write_register(REG_COUNT, reg_data);
                wrote = 1'b1;
            end
            if ($urandom_range(0, 1) == 1) begin
                lo_bound = $urandom;
                hi_bound = $urandom;
                case ($urandom_range(0, 9))
                    0: begin
                        lo_bound = 32'h8000_0000;
                        hi_bound = 32'h7FFF_FFFF;
                    end
                    1: hi_bound = lo_bound;                         // empty interval
                    2: begin                                        // reversed
                        if ($signed(lo_bound) < $signed(hi_bound)) begin
                            swap = lo_bound; lo_bound = hi_bound; hi_bound = swap;
                        end
                    end
                    3: hi_bound = lo_bound + $urandom_range(1, 32'h0004_0000);
                    default: begin
                        if ($signed(lo_bound) > $signed(hi_bound)) begin
                            swap = lo_bound; lo_bound = hi_bound; hi_bound = swap;
                        end
                    end
                endcase
                // occasionally only one bound moves
                if ($urandom_range(0, 3) != 0) write_register(REG_X_START, lo_bound);
                write_register(REG_X_END, hi_bound);
                wrote = 1'b1;
            end
            if (wrote) end_register_writes();

            if (config_status() != STATUS_OK) begin
                requests = $urandom_range(2, 8);
            end else begin
                set_size = (cfg_rule == RULE_RECT) ? effective_count() : effective_count() + 1;
                requests = set_size * $urandom_range(1, 4);
                if (set_size > 1 && $urandom_range(0, 3) == 0)
                    requests += $urandom_range(1, set_size - 1);
            end
            gap_mode = ($urandom_range(0, 4) == 0) ? GAP_NONE : GAP_MIXED;

            for (int i = 0; i < requests; i++) begin
                send_sample(pick_sample(), gap_mode, 1'b0, no_result);
                random_samples++;
                if ($urandom_range(0, 39) == 0) pause_for_results();
            end
        end

        // Drain, then give the block time to show any stray result
        pause_for_results();
        repeat (LATENCY_CYCLES) @(posedge i_clk);
        if (awaited_results.size() != 0) begin
            $error("%0d integrals never arrived", awaited_results.size());
            mismatch_count++;
        end

        $display("Run covered %0d samples (%0d in the clamped-count Simpson set) over %0d writes.",
                 samples_sent, long_set_samples, register_writes);
        $display("Compared %0d integrals, %0d of them configuration error responses.",
                 results_checked, error_results);
        if (mismatch_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial begin : watchdog
        #50_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
